[rtl/tzbd_pkg.sv]
// shared types, constants and sensor zone table for the touch zone button decoder
package tzbd_pkg;

   localparam int BUTTON_COUNT      = 6;
   localparam int SENSOR_COUNT      = 10;
   localparam int DEF_COUNT_BITS    = 16;
   localparam int DEF_QUEUE_DEPTH   = 4;
   localparam int FIELD_COUNT_BITS  = 16;
   localparam int BUTTON_INDEX_BITS = 3;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 9;
   localparam int COORD_BITS        = 18;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAD_LEFT     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAD_TOP      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOUCH_RADIUS = 2'd2;

   localparam logic CMD_TOUCH = 1'b0;
   localparam logic CMD_FRAME = 1'b1;

   typedef struct packed {
      logic              command;
      logic signed [15:0] touch_x;
      logic signed [15:0] touch_y;
   } req_payload_type;

   typedef struct packed {
      logic [BUTTON_INDEX_BITS-1:0] button_index;
      logic [FIELD_COUNT_BITS-1:0]  hold_count;
      logic [FIELD_COUNT_BITS-1:0]  release_count;
      logic                         last_button;
   } rsp_payload_type;

   typedef struct packed {
      logic                    frame;
      logic [BUTTON_COUNT-1:0] hit_mask;
   } queue_entry_type;

   typedef struct packed {
      logic [3:0]              xt;
      logic [3:0]              yt;
      logic [1:0]              wt;
      logic [1:0]              ht;
      logic [BUTTON_COUNT-1:0] bits;
   } zone_type;

   // button bits: 0 up, 1 down, 2 left, 3 right, 4 A, 5 B
   localparam zone_type ZONES [SENSOR_COUNT] = '{
      '{xt: 4'd0,  yt: 4'd0, wt: 2'd2, ht: 2'd2, bits: 6'h05},
      '{xt: 4'd2,  yt: 4'd0, wt: 2'd2, ht: 2'd2, bits: 6'h01},
      '{xt: 4'd4,  yt: 4'd0, wt: 2'd2, ht: 2'd2, bits: 6'h09},
      '{xt: 4'd0,  yt: 4'd2, wt: 2'd2, ht: 2'd2, bits: 6'h04},
      '{xt: 4'd4,  yt: 4'd2, wt: 2'd2, ht: 2'd2, bits: 6'h08},
      '{xt: 4'd0,  yt: 4'd4, wt: 2'd2, ht: 2'd2, bits: 6'h06},
      '{xt: 4'd2,  yt: 4'd4, wt: 2'd2, ht: 2'd2, bits: 6'h02},
      '{xt: 4'd4,  yt: 4'd4, wt: 2'd2, ht: 2'd2, bits: 6'h0A},
      '{xt: 4'd7,  yt: 4'd3, wt: 2'd3, ht: 2'd3, bits: 6'h20},
      '{xt: 4'd11, yt: 4'd3, wt: 2'd3, ht: 2'd3, bits: 6'h10}
   };

endpackage

[rtl/tzbd_front.sv]
// front end: configuration registers and parallel touch square against sensor zone test
module tzbd_front import tzbd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  req_payload_type           req_payload,
   output queue_entry_type           entry
);

   logic [8:0] pad_left_ff;
   logic [8:0] pad_top_ff;
   logic [7:0] touch_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_left_ff     <= '0;
         pad_top_ff      <= '0;
         touch_radius_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PAD_LEFT:     pad_left_ff     <= csr_wdata;
            CSR_PAD_TOP:      pad_top_ff      <= csr_wdata;
            CSR_TOUCH_RADIUS: touch_radius_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   logic signed [COORD_BITS-1:0] tx;
   logic signed [COORD_BITS-1:0] ty;
   logic signed [COORD_BITS-1:0] rad;
   logic signed [COORD_BITS-1:0] x0;
   logic signed [COORD_BITS-1:0] x1;
   logic signed [COORD_BITS-1:0] y0;
   logic signed [COORD_BITS-1:0] y1;
   logic [BUTTON_COUNT-1:0]      hits;

   assign tx  = {{2{req_payload.touch_x[15]}}, req_payload.touch_x};
   assign ty  = {{2{req_payload.touch_y[15]}}, req_payload.touch_y};
   assign rad = {6'b0, touch_radius_ff, 4'b0};
   assign x0  = tx - rad;
   assign x1  = tx + rad;
   assign y0  = ty - rad;
   assign y1  = ty + rad;

   always_comb begin
      logic [9:0]                   px;
      logic [9:0]                   py;
      logic signed [COORD_BITS-1:0] zx0;
      logic signed [COORD_BITS-1:0] zy0;
      logic signed [COORD_BITS-1:0] zx1;
      logic signed [COORD_BITS-1:0] zy1;
      hits = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         px  = 10'(pad_left_ff) + {3'b0, ZONES[i].xt, 3'b0};
         py  = 10'(pad_top_ff) + {3'b0, ZONES[i].yt, 3'b0};
         zx0 = {4'b0, px, 4'b0};
         zy0 = {4'b0, py, 4'b0};
         zx1 = zx0 + {9'b0, ZONES[i].wt, 7'b0};
         zy1 = zy0 + {9'b0, ZONES[i].ht, 7'b0};
         if (!(x0 > zx1 || x1 < zx0 || y0 > zy1 || y1 < zy0)) begin
            hits = hits | ZONES[i].bits;
         end
      end
   end

   assign entry.frame    = (req_payload.command == CMD_FRAME);
   assign entry.hit_mask = entry.frame ? '0 : hits;

endmodule

[rtl/tzbd_queue.sv]
// short queue of classified items between front and back
module tzbd_queue import tzbd_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            head_valid,
   output queue_entry_type head_entry
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   queue_entry_type       mem [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_BITS'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/tzbd_back.sv]
// back end: pending mask, hold and release counters, result sequencing
module tzbd_back import tzbd_pkg::*; #(
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  queue_entry_type head_entry,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int WIDE_BITS = (COUNT_BITS > FIELD_COUNT_BITS) ? COUNT_BITS : FIELD_COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [BUTTON_INDEX_BITS-1:0] LAST_INDEX = BUTTON_INDEX_BITS'(BUTTON_COUNT - 1);

   logic [BUTTON_COUNT-1:0]      pending_ff, pending_in;
   logic [COUNT_BITS-1:0]        hold_ff [BUTTON_COUNT];
   logic [COUNT_BITS-1:0]        hold_in [BUTTON_COUNT];
   logic [COUNT_BITS-1:0]        release_ff [BUTTON_COUNT];
   logic [COUNT_BITS-1:0]        release_in [BUTTON_COUNT];
   logic                         busy_ff, busy_in;
   logic [BUTTON_INDEX_BITS-1:0] idx_ff, idx_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_payload_type              rsp_payload_ff, rsp_payload_in;
   logic                         out_free;
   logic [WIDE_BITS-1:0]         hold_wide;
   logic [WIDE_BITS-1:0]         release_wide;

   assign pop         = head_valid && !busy_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign hold_wide    = WIDE_BITS'(hold_ff[idx_ff]);
   assign release_wide = WIDE_BITS'(release_ff[idx_ff]);

   always_comb begin
      pending_in     = pending_ff;
      hold_in        = hold_ff;
      release_in     = release_ff;
      busy_in        = busy_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (pop) begin
         if (head_entry.frame) begin
            for (int i = 0; i < BUTTON_COUNT; i++) begin
               if (pending_ff[i]) begin
                  hold_in[i]    = (hold_ff[i] == COUNT_MAX) ? hold_ff[i] : hold_ff[i] + 1'b1;
                  release_in[i] = '0;
               end else begin
                  hold_in[i]    = '0;
                  release_in[i] = (release_ff[i] == COUNT_MAX) ? release_ff[i]
                                                                : release_ff[i] + 1'b1;
               end
            end
            pending_in = '0;
            busy_in    = 1'b1;
            idx_in     = '0;
         end else begin
            pending_in = pending_ff | head_entry.hit_mask;
         end
      end
      if (out_free) begin
         rsp_valid_in = busy_ff;
         if (busy_ff) begin
            rsp_payload_in.button_index  = idx_ff;
            rsp_payload_in.hold_count    = hold_wide[FIELD_COUNT_BITS-1:0];
            rsp_payload_in.release_count = release_wide[FIELD_COUNT_BITS-1:0];
            rsp_payload_in.last_button   = (idx_ff == LAST_INDEX);
            idx_in = (idx_ff == LAST_INDEX) ? '0 : idx_ff + 1'b1;
            if (idx_ff == LAST_INDEX) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            hold_ff[i]    <= '0;
            release_ff[i] <= '0;
         end
      end else begin
         pending_ff   <= pending_in;
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         hold_ff      <= hold_in;
         release_ff   <= release_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

[rtl/touch_zone_button_decoder_core.sv]
// top level of the touch zone button decoder
// touch items: one transfer per cycle unless stalled; hit mask queued, then ORed into pending
// frame items: queued, popped to start the results, then one result per cycle unless stalled
// a frame holds the back end busy from the pop until the last button result is issued
// the front keeps taking items into a queue of QUEUE_DEPTH entries meanwhile
// synchronous reset clears configuration, pending mask, counters, queue and output valid
module touch_zone_button_decoder_core import tzbd_pkg::*; #(
   parameter int COUNT_BITS  = DEF_COUNT_BITS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload
);

   queue_entry_type front_entry;
   queue_entry_type head_entry;
   logic            queue_full;
   logic            head_valid;
   logic            pop;
   logic            push;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   tzbd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .entry       (front_entry)
   );

   tzbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   tzbd_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[rtl/tzbd_checker.sv]
// port level assertions for the touch zone button decoder, bound to the top level
module tzbd_checker import tzbd_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   localparam logic [BUTTON_INDEX_BITS-1:0] LAST_INDEX = BUTTON_INDEX_BITS'(BUTTON_COUNT - 1);

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.button_index <= LAST_INDEX)
      else $error("button index out of range");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.last_button == (rsp_payload.button_index == LAST_INDEX))
      else $error("last flag does not match button index");

   a_counts_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.hold_count == '0 || rsp_payload.release_count == '0)
      else $error("hold and release counts both nonzero");

   a_next_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last_button ##1 rsp_valid
      |-> rsp_payload.button_index == $past(rsp_payload.button_index) + 1'b1)
      else $error("button results out of order");

endmodule

bind touch_zone_button_decoder_core tzbd_checker u_tzbd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
